// ===== hw/rtl/lpim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared types and constants for the linear-probing integer map.
// ----------------------------------------------------------------------------
package lpim_pkg;

    // Table geometry: the slot count is a power of two.
    localparam int TABLE_SIZE = 256;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int USED_W     = ADDR_W + 1;

    // Payload widths.
    localparam int FUNC_W  = 3;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int LIMIT_W = 8;
    localparam int CMP_W   = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET    = 3'd0,
        FUNC_GET    = 3'd1,
        FUNC_HAS    = 3'd2,
        FUNC_DELETE = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    // Slot status codes as held in the status memory.
    localparam int SLOT_W = 2;
    typedef enum logic [SLOT_W-1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_DATA  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot;

endpackage

// ===== hw/rtl/lpim_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/linear_probe_integer_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_integer_map
// Open-addressing map with 64-bit keys and values and linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   An item (i_func, i_key, i_value) is taken at a rising edge where start is
//   high and busy is low. Each item gives exactly one result on
//   o_result_value, o_found and o_refused, shown for one cycle with o_done.
//   The receiver cannot stall; results are never held back.
//   Set, get, has and delete walk the table from the home slot (the low key
//   bits), one slot per cycle, reading the key, value and status memories
//   together. An operation keeps busy high while it probes and shows its
//   result in the cycle after the last probe; the single read port per memory
//   sets the one-probe-per-cycle pace. At worst TABLE_SIZE slots are probed.
//   Clear and unused codes never raise busy. The load limit register is
//   written through i_cfg_we / i_cfg_data; the user must write it only while
//   the block is idle, as the block does not enforce this. Reset empties the
//   table at once (per-slot valid bits) and sets the load limit to 128; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_probe_integer_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lpim_pkg::FUNC_W-1:0]    i_func,
    input  logic [lpim_pkg::KEY_W-1:0]     i_key,
    input  logic [lpim_pkg::VAL_W-1:0]     i_value,
    input  logic                           i_cfg_we,
    input  logic [lpim_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic                           o_done,
    output logic [lpim_pkg::VAL_W-1:0]     o_result_value,
    output logic                           o_found,
    output logic                           o_refused
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PROBE = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Operation registers.
    lpim_pkg::t_func                  r_func;
    logic [lpim_pkg::KEY_W-1:0]       r_key;
    logic [lpim_pkg::VAL_W-1:0]       r_value;
    logic [lpim_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic [lpim_pkg::ADDR_W-1:0]      r_cnt, n_cnt;

    // Table bookkeeping.
    logic [lpim_pkg::TABLE_SIZE-1:0]  r_slot_vld;
    logic                             r_vld_rd;
    logic [lpim_pkg::USED_W-1:0]      r_used;
    logic [lpim_pkg::LIMIT_W-1:0]     r_load_limit;

    // Result registers.
    logic                             r_done, n_done;
    logic [lpim_pkg::VAL_W-1:0]       r_res, n_res;
    logic                             r_found, n_found;
    logic                             r_refused, n_refused;

    // Memory ports.
    logic [lpim_pkg::ADDR_W-1:0]      rd_addr;
    logic [lpim_pkg::KEY_W-1:0]       key_rdata;
    logic [lpim_pkg::VAL_W-1:0]       val_rdata;
    logic [lpim_pkg::SLOT_W-1:0]      st_rdata;
    logic                             key_we, val_we, st_we;
    logic [lpim_pkg::SLOT_W-1:0]      st_wdata;

    // Control decode.
    logic                             accept;
    lpim_pkg::t_slot                  slot_st;
    logic                             slot_empty, slot_hit;
    logic                             room;
    logic                             do_clear, do_insert;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // A slot whose valid bit is clear reads as empty.
    assign slot_st    = r_vld_rd ? lpim_pkg::t_slot'(st_rdata) : lpim_pkg::SLOT_EMPTY;
    assign slot_empty = (slot_st == lpim_pkg::SLOT_EMPTY);
    assign slot_hit   = (slot_st == lpim_pkg::SLOT_DATA) && (key_rdata == r_key);
    assign room       = lpim_pkg::CMP_W'(r_used) < lpim_pkg::CMP_W'(r_load_limit);

    // Memories: keys, values and slot status share one address stream.
    lpim_ram #(.WIDTH(lpim_pkg::KEY_W), .DEPTH(lpim_pkg::TABLE_SIZE)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_rdata)
    );

    lpim_ram #(.WIDTH(lpim_pkg::VAL_W), .DEPTH(lpim_pkg::TABLE_SIZE)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_idx),
        .i_wdata (r_value),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    lpim_ram #(.WIDTH(lpim_pkg::SLOT_W), .DEPTH(lpim_pkg::TABLE_SIZE)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (st_wdata),
        .i_raddr (rd_addr),
        .o_rdata (st_rdata)
    );

    // Sequencer: launch a probe on accept of set, get, has or delete, then check one slot per cycle.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_res     = '0;
        n_found   = 1'b0;
        n_refused = 1'b0;
        rd_addr   = i_key[lpim_pkg::ADDR_W-1:0];
        key_we    = 1'b0;
        val_we    = 1'b0;
        st_we     = 1'b0;
        st_wdata  = lpim_pkg::SLOT_DATA;
        do_clear  = 1'b0;
        do_insert = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx = i_key[lpim_pkg::ADDR_W-1:0];
                    n_cnt = '0;
                    if (i_func == lpim_pkg::FUNC_SET || i_func == lpim_pkg::FUNC_GET ||
                        i_func == lpim_pkg::FUNC_HAS || i_func == lpim_pkg::FUNC_DELETE) begin
                        n_state = ST_PROBE;
                    end else begin
                        // Clear and unused codes answer with all zeros at once.
                        do_clear = (i_func == lpim_pkg::FUNC_CLEAR);
                        n_done   = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                rd_addr = r_idx + lpim_pkg::ADDR_W'(1);
                if (slot_hit) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    case (r_func)
                        lpim_pkg::FUNC_SET: begin
                            n_res  = val_rdata;
                            val_we = 1'b1;
                        end
                        lpim_pkg::FUNC_GET: begin
                            n_res = val_rdata;
                        end
                        lpim_pkg::FUNC_DELETE: begin
                            st_we    = 1'b1;
                            st_wdata = lpim_pkg::SLOT_TOMB;
                        end
                        default: begin
                        end
                    endcase
                end else if (slot_empty) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    if (r_func == lpim_pkg::FUNC_SET) begin
                        if (room) begin
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            st_we     = 1'b1;
                            do_insert = 1'b1;
                        end else begin
                            n_refused = 1'b1;
                        end
                    end
                end else if (r_cnt == lpim_pkg::ADDR_W'(lpim_pkg::TABLE_SIZE - 1)) begin
                    // Whole table walked without an empty slot or a match.
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_refused = (r_func == lpim_pkg::FUNC_SET);
                end else begin
                    n_idx = r_idx + lpim_pkg::ADDR_W'(1);
                    n_cnt = r_cnt + lpim_pkg::ADDR_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_done       <= 1'b0;
            r_slot_vld   <= '0;
            r_used       <= '0;
            r_load_limit <= lpim_pkg::LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_load_limit <= i_cfg_data;
            end
            if (do_clear) begin
                r_slot_vld <= '0;
                r_used     <= '0;
            end else if (do_insert) begin
                r_slot_vld[r_idx] <= 1'b1;
                r_used            <= r_used + lpim_pkg::USED_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= lpim_pkg::t_func'(i_func);
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_vld_rd  <= r_slot_vld[rd_addr];
        r_res     <= n_res;
        r_found   <= n_found;
        r_refused <= n_refused;
    end

    assign o_done         = r_done;
    assign o_result_value = r_res;
    assign o_found        = r_found;
    assign o_refused      = r_refused;

endmodule

// ===== bench/linear_probe_integer_map_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_integer_map_checker
// Watches the item and result channels of the integer map, keeps its own copy
// of the table, predicts the result of every accepted item and compares each
// result field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module linear_probe_integer_map_checker
    import lpim_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_value,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_done,
    input  logic [VAL_W-1:0]   i_result_value,
    input  logic               i_found,
    input  logic               i_refused,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_hits,
    output int                 o_refusals
);

    // Outcome of a walk along the probe sequence.
    typedef enum logic [1:0] {
        WALK_HIT,
        WALK_FREE,
        WALK_EXHAUSTED
    } t_walk;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
        logic             refused;
    } t_map_reply;

    // Shadow copy of the table and the load limit.
    logic [KEY_W-1:0]   shadow_keys [TABLE_SIZE];
    logic [VAL_W-1:0]   shadow_vals [TABLE_SIZE];
    t_slot              shadow_state [TABLE_SIZE];
    int unsigned        occupied_slots;
    logic [LIMIT_W-1:0] load_limit;

    t_map_reply replies_due [$];
    t_map_reply predicted;
    t_map_reply observed;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what);
        o_errors++;
        $display("[%0t ns] map mismatch: %s", $time, what);
    endtask

    // Walks from the home slot, passing over tombs and other keys, until an
    // empty slot or a live slot holding the key is met, or the whole table is walked.
    function automatic t_walk walk_to_slot(input logic [KEY_W-1:0] key,
                                           output int unsigned slot);
        int unsigned idx;
        idx  = 32'(key[ADDR_W-1:0]);
        slot = 0;
        for (int n = 0; n < TABLE_SIZE; n++) begin
            if (shadow_state[idx] == SLOT_EMPTY) begin
                slot = idx;
                return WALK_FREE;
            end
            if (shadow_state[idx] == SLOT_DATA && shadow_keys[idx] == key) begin
                slot = idx;
                return WALK_HIT;
            end
            idx = (idx + 1) % TABLE_SIZE;
        end
        return WALK_EXHAUSTED;
    endfunction

    // Applies one operation to the shadow table and gives the reply it causes.
    task automatic apply_operation(input logic [FUNC_W-1:0] func,
                                   input logic [KEY_W-1:0] key,
                                   input logic [VAL_W-1:0] value,
                                   output t_map_reply reply);
        int unsigned slot;
        t_walk       outcome;
        reply = '0;
        case (func)
            FUNC_SET: begin
                outcome = walk_to_slot(key, slot);
                if (outcome == WALK_HIT) begin
                    reply.value       = shadow_vals[slot];
                    reply.found       = 1'b1;
                    shadow_vals[slot] = value;
                end else if (outcome == WALK_FREE && occupied_slots < load_limit) begin
                    shadow_keys[slot]  = key;
                    shadow_vals[slot]  = value;
                    shadow_state[slot] = SLOT_DATA;
                    occupied_slots++;
                end else begin
                    reply.refused = 1'b1;
                end
            end
            FUNC_GET: begin
                if (walk_to_slot(key, slot) == WALK_HIT) begin
                    reply.value = shadow_vals[slot];
                    reply.found = 1'b1;
                end
            end
            FUNC_HAS: begin
                if (walk_to_slot(key, slot) == WALK_HIT) begin
                    reply.found = 1'b1;
                end
            end
            FUNC_DELETE: begin
                if (walk_to_slot(key, slot) == WALK_HIT) begin
                    shadow_state[slot] = SLOT_TOMB;
                    reply.found        = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                foreach (shadow_state[i]) begin
                    shadow_state[i] = SLOT_EMPTY;
                end
                occupied_slots = 0;
            end
            default: begin
            end
        endcase
    endtask

    // Accepted items are predicted before results are compared, so that the
    // queue is in order whatever the latency.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_state[i]) begin
                shadow_state[i] = SLOT_EMPTY;
            end
            occupied_slots = 0;
            load_limit     = LIMIT_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                load_limit = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                apply_operation(i_func, i_key, i_value, predicted);
                replies_due.push_back(predicted);
            end
            if (i_done) begin
                observed = '{value: i_result_value, found: i_found, refused: i_refused};
                if (replies_due.size() == 0) begin
                    report_mismatch("result arrived with no item outstanding");
                end else begin
                    predicted = replies_due.pop_front();
                    o_results++;
                    if (observed.found) o_hits++;
                    if (observed.refused) o_refusals++;
                    if (observed.value !== predicted.value) begin
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  observed.value, predicted.value));
                    end
                    if (observed.found !== predicted.found) begin
                        report_mismatch($sformatf("found %b, expected %b",
                                                  observed.found, predicted.found));
                    end
                    if (observed.refused !== predicted.refused) begin
                        report_mismatch($sformatf("refused %b, expected %b",
                                                  observed.refused, predicted.refused));
                    end
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== bench/tb_linear_probe_integer_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_integer_map
// Drives the integer map with a directed opening and then random phases at a
// range of load limits, including a phase that fills the table. A checker
// beside the block predicts and compares every result; this module makes the
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_linear_probe_integer_map;
    import lpim_pkg::*;

    // Codes with no operation behind them.
    localparam logic [FUNC_W-1:0] FUNC_NOP_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_NOP_LAST  = 3'd7;
    localparam logic [KEY_W-1:0]  ALL_ONES       = '1;
    localparam int                POOL_SIZE      = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [FUNC_W-1:0]  i_func;
    logic [KEY_W-1:0]   i_key;
    logic [VAL_W-1:0]   i_value;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;
    logic               o_done;
    logic [VAL_W-1:0]   o_result_value;
    logic               o_found;
    logic               o_refused;

    int mismatches;
    int outstanding;
    int results_seen;
    int hits_seen;
    int refusals_seen;

    int               items_sent;
    int               limits_used;
    bit               no_idle;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_W-1:0] filled_keys [$];

    linear_probe_integer_map dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_found        (o_found),
        .o_refused      (o_refused)
    );

    linear_probe_integer_map_checker map_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_done         (o_done),
        .i_result_value (o_result_value),
        .i_found        (o_found),
        .i_refused      (o_refused),
        .o_errors       (mismatches),
        .o_pending      (outstanding),
        .o_results      (results_seen),
        .o_hits         (hits_seen),
        .o_refusals     (refusals_seen)
    );

    // 12 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog, well above the slowest correct run with every probe at full length.
    initial begin
        #25_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one item after a random gap and holds it until the block takes it.
    // Called and returns at a falling edge; start stays high for a following item.
    task automatic send_item(input logic [FUNC_W-1:0] func,
                             input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   = 1'b1;
        i_func  = func;
        i_key   = key;
        i_value = value;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Stops offering items until every outstanding result has come back.
    task automatic wait_idle();
        start = 1'b0;
        do @(negedge i_clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] limit);
        wait_idle();
        i_cfg_we   = 1'b1;
        i_cfg_data = limit;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        limits_used++;
    endtask

    // Keys clustered around a few home slots so that probes collide and wrap.
    task automatic refill_pool();
        logic [ADDR_W-1:0] cluster;
        logic [KEY_W-1:0]  key;
        cluster = ADDR_W'($urandom_range(0, TABLE_SIZE - 1));
        foreach (key_pool[i]) begin
            key = rand64();
            if (i % 8 == 0) cluster = ADDR_W'($urandom_range(0, TABLE_SIZE - 1));
            key[ADDR_W-1:0] = cluster + ADDR_W'($urandom_range(0, 5));
            key_pool[i] = key;
        end
    endtask

    function automatic logic [FUNC_W-1:0] pick_func();
        int unsigned       roll;
        logic [FUNC_W-1:0] func;
        roll = $urandom_range(0, 99);
        if (roll < 40)      func = FUNC_SET;
        else if (roll < 60) func = FUNC_GET;
        else if (roll < 74) func = FUNC_HAS;
        else if (roll < 94) func = FUNC_DELETE;
        else if (roll < 97) func = FUNC_CLEAR;
        else                func = FUNC_W'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
        return func;
    endfunction

    // Mostly pool keys; some share a home slot with a pool key but differ above it, some are random.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned      roll;
        logic [KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll >= 85) begin
            key = rand64();
        end else if (roll >= 75) begin
            key[KEY_W-1:ADDR_W] = (KEY_W - ADDR_W)'(rand64());
        end
        return key;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 10) return ALL_ONES;
        return rand64();
    endfunction

    // One random phase at a given load limit, with a drain half way through and at random points.
    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int count);
        write_limit(limit);
        refill_pool();
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (n == count / 2 || $urandom_range(0, 99) == 0) wait_idle();
            send_item(pick_func(), pick_key(), pick_value());
        end
    endtask

    // Fills the table up to the highest limit, then works on the filled keys.
    task automatic fill_table();
        logic [KEY_W-1:0] key;
        write_limit(8'd255);
        no_idle = 1'b0;
        send_item(FUNC_CLEAR, rand64(), rand64());
        filled_keys.delete();
        repeat (300) begin
            key = rand64();
            filled_keys.push_back(key);
            send_item(FUNC_SET, key, pick_value());
        end
        repeat (60) begin
            key = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
            send_item(pick_func(), key, pick_value());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = FUNC_SET;
        i_key      = '0;
        i_value    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        items_sent  = 0;
        limits_used = 0;
        no_idle     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening at the reset limit: collisions on home slot 0, a
        // probe that wraps from the top slot, replacement, tombs and misses.
        send_item(FUNC_SET, 64'h0, ALL_ONES);
        send_item(FUNC_SET, ALL_ONES, 64'h0);
        send_item(FUNC_SET, 64'h100, 64'h1234);
        send_item(FUNC_SET, 64'h1FF, 64'h5A5A_0000_FFFF_C3C3);
        send_item(FUNC_GET, 64'h1FF, 64'h0);
        send_item(FUNC_GET, 64'h2FF, 64'h0);
        send_item(FUNC_HAS, 64'h100, ALL_ONES);
        send_item(FUNC_HAS, 64'h200, 64'h0);
        send_item(FUNC_SET, 64'h0, 64'hA5A5_A5A5_A5A5_A5A5);
        send_item(FUNC_DELETE, 64'h100, 64'h0);
        // Delete of a key that is no longer live, then lookups past the tomb.
        send_item(FUNC_DELETE, 64'h100, 64'h0);
        send_item(FUNC_GET, 64'h100, 64'h0);
        send_item(FUNC_GET, 64'h1FF, 64'h0);
        send_item(FUNC_SET, 64'h100, 64'h7);
        send_item(FUNC_NOP_FIRST, ALL_ONES, ALL_ONES);
        send_item(FUNC_NOP_FIRST + 3'd1, 64'h0, ALL_ONES);
        send_item(FUNC_NOP_LAST, 64'h100, 64'h1);
        send_item(FUNC_CLEAR, ALL_ONES, ALL_ONES);
        send_item(FUNC_GET, 64'h0, 64'h0);

        // Smallest limits: one slot, then none; a tomb still holds its slot.
        write_limit(8'd1);
        send_item(FUNC_SET, 64'h55, 64'h1);
        send_item(FUNC_SET, 64'h66, 64'h2);
        send_item(FUNC_SET, 64'h55, 64'h3);
        send_item(FUNC_DELETE, 64'h55, 64'h0);
        send_item(FUNC_SET, 64'h77, 64'h4);
        write_limit(8'd0);
        send_item(FUNC_SET, 64'h88, 64'h5);
        send_item(FUNC_CLEAR, 64'h0, 64'h0);

        fill_table();
        run_phase(8'd128, 120);
        run_phase(8'd1, 120);
        run_phase(8'd2, 120);
        run_phase(8'd64, 120);
        run_phase(LIMIT_W'($urandom_range(1, 255)), 120);
        run_phase(8'd255, 120);
        run_phase(8'd3, 120);
        run_phase(LIMIT_W'($urandom_range(1, 255)), 120);
        run_phase(8'd200, 120);
        run_phase(LIMIT_W'($urandom_range(1, 255)), 120);
        run_phase(8'd128, 120);

        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d items over %0d load-limit settings; %0d results checked.",
                 items_sent, limits_used, results_seen);
        $display("Results included %0d key hits and %0d refused inserts; %0d mismatches.",
                 hits_seen, refusals_seen, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
